// File: rtl/tdpt_pkg.sv
// Package: constants, microcode control word and program ROM for the trial division test.
`default_nettype none
package tdpt_pkg;

	localparam int unsigned VALUE_WIDTH_DEF = 32;

	localparam int unsigned STEP_W = 3;
	localparam int unsigned COND_W = 3;

	localparam logic [STEP_W-1:0] S_IDLE  = 3'd0;
	localparam logic [STEP_W-1:0] S_CHECK = 3'd1;
	localparam logic [STEP_W-1:0] S_DINIT = 3'd2;
	localparam logic [STEP_W-1:0] S_DSTEP = 3'd3;
	localparam logic [STEP_W-1:0] S_TEST  = 3'd4;
	localparam logic [STEP_W-1:0] S_EMIT  = 3'd5;
	localparam logic [STEP_W-1:0] S_WAIT  = 3'd6;

	localparam logic [COND_W-1:0] C_NEVER    = 3'd0;
	localparam logic [COND_W-1:0] C_ALWAYS   = 3'd1;
	localparam logic [COND_W-1:0] C_NO_IN    = 3'd2;
	localparam logic [COND_W-1:0] C_SMALL    = 3'd3;
	localparam logic [COND_W-1:0] C_DIV_BUSY = 3'd4;
	localparam logic [COND_W-1:0] C_AGAIN    = 3'd5;
	localparam logic [COND_W-1:0] C_OUT_FREE = 3'd6;

	typedef struct packed {
		logic              in_rdy;
		logic              ld;
		logic              dinit;
		logic              dstep;
		logic              dtest;
		logic              emit;
		logic [COND_W-1:0] cond;
		logic [STEP_W-1:0] target;
	} ctrl_t;

	function automatic ctrl_t rom_word(input logic [STEP_W-1:0] step);
		ctrl_t w;
		w = '0;
		case (step)
			S_IDLE: begin
				w.in_rdy = 1'b1;
				w.ld     = 1'b1;
				w.cond   = C_NO_IN;
				w.target = S_IDLE;
			end
			S_CHECK: begin
				w.cond   = C_SMALL;
				w.target = S_EMIT;
			end
			S_DINIT: begin
				w.dinit  = 1'b1;
				w.cond   = C_NEVER;
				w.target = S_IDLE;
			end
			S_DSTEP: begin
				w.dstep  = 1'b1;
				w.cond   = C_DIV_BUSY;
				w.target = S_DSTEP;
			end
			S_TEST: begin
				w.dtest  = 1'b1;
				w.cond   = C_AGAIN;
				w.target = S_DINIT;
			end
			S_EMIT: begin
				w.emit   = 1'b1;
				w.cond   = C_OUT_FREE;
				w.target = S_IDLE;
			end
			S_WAIT: begin
				w.cond   = C_ALWAYS;
				w.target = S_EMIT;
			end
			default: begin
				w.cond   = C_ALWAYS;
				w.target = S_IDLE;
			end
		endcase
		return w;
	endfunction

endpackage
`default_nettype wire

// File: rtl/tdpt_if.sv
// Interfaces: candidate and result channels with valid/ready handshake.
`default_nettype none
interface tdpt_cand_if #(
	parameter int unsigned VALUE_WIDTH = tdpt_pkg::VALUE_WIDTH_DEF
);
	logic                          valid;
	logic                          ready;
	logic signed [VALUE_WIDTH-1:0] candidate_value;

	modport source (output valid, output candidate_value, input ready);
	modport sink (input valid, input candidate_value, output ready);
endinterface

interface tdpt_flag_if;
	logic valid;
	logic ready;
	logic prime_flag;

	modport source (output valid, output prime_flag, input ready);
	modport sink (input valid, input prime_flag, output ready);
endinterface
`default_nettype wire

// File: rtl/trial_division_primality_test.sv
// Top level: microcoded trial division primality test with a shared radix-2 divider.
//
//  channel    dir  payload                        transaction
//  candidate  in   candidate_value[VALUE_WIDTH]   valid & ready
//  result     out  prime_flag                     valid & ready
//
// Each divisor d costs one init step, VALUE_WIDTH restoring divider steps and
// one test step. Values below two, negative values among them, go from the
// check step straight to the emit step. Reset clears the step counter and
// the result valid flag. A stalled result holds in the output register while
// the next candidate is taken.
`default_nettype none
module trial_division_primality_test #(
	parameter int unsigned VALUE_WIDTH = tdpt_pkg::VALUE_WIDTH_DEF
) (
	input  wire                 clk,
	input  wire                 arst_n,
	tdpt_cand_if.sink           candidate,
	tdpt_flag_if.source         result
);
	import tdpt_pkg::*;

	localparam int unsigned W   = VALUE_WIDTH;
	localparam int unsigned CNT_W = $clog2(W + 1);

	logic [STEP_W-1:0] step_q;
	logic [STEP_W-1:0] step_nxt;
	ctrl_t             cw;
	logic              jump;

	logic [W-1:0]      n_q;
	logic [W-1:0]      d_q;
	logic [W-1:0]      rem_q;
	logic [W-1:0]      quo_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              prime_q;
	logic              out_valid_q;
	logic              out_flag_q;

	logic              in_acc;
	logic              below_two;
	logic              resolved;
	logic              out_free;
	logic [W:0]        rem_sh;
	logic [W-1:0]      rem_sub;
	logic              sub_ok;

	assign cw = rom_word(step_q);

	assign in_acc    = cw.in_rdy & candidate.valid;
	assign below_two = n_q[W-1] | (n_q < W'(2));
	assign resolved  = (quo_q < d_q) | (rem_q == '0);
	assign out_free  = ~out_valid_q | result.ready;

	assign rem_sh  = {rem_q, quo_q[W-1]};
	assign rem_sub = rem_sh[W-1:0] - d_q;
	assign sub_ok  = rem_sh >= {1'b0, d_q};

	always_comb begin
		case (cw.cond)
			C_NEVER:    jump = 1'b0;
			C_ALWAYS:   jump = 1'b1;
			C_NO_IN:    jump = ~candidate.valid;
			C_SMALL:    jump = below_two;
			C_DIV_BUSY: jump = cnt_q != CNT_W'(1);
			C_AGAIN:    jump = ~resolved;
			C_OUT_FREE: jump = out_free;
			default:    jump = 1'b1;
		endcase
		step_nxt = jump ? cw.target : step_q + STEP_W'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			step_q <= step_nxt;
			if (cw.emit && out_free) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cw.ld && in_acc) begin
			n_q     <= candidate.candidate_value;
			d_q     <= W'(2);
			prime_q <= 1'b0;
		end
		if (cw.dinit) begin
			rem_q <= '0;
			quo_q <= n_q;
			cnt_q <= CNT_W'(W);
		end
		if (cw.dstep) begin
			rem_q <= sub_ok ? rem_sub : rem_sh[W-1:0];
			quo_q <= {quo_q[W-2:0], sub_ok};
			cnt_q <= cnt_q - CNT_W'(1);
		end
		if (cw.dtest) begin
			prime_q <= quo_q < d_q;
			if (!resolved) begin
				d_q <= d_q + W'(1);
			end
		end
		if (cw.emit && out_free) begin
			out_flag_q <= prime_q;
		end
	end

	assign candidate.ready   = cw.in_rdy;
	assign result.valid      = out_valid_q;
	assign result.prime_flag = out_flag_q;

endmodule
`default_nettype wire

// File: rtl/tdpt_checker.sv
// Checker: port-level assertions for the trial division primality test, bound to the top level.
`default_nettype none
module tdpt_checker (
	input wire clk,
	input wire arst_n,
	input wire in_valid,
	input wire in_ready,
	input wire out_valid,
	input wire out_ready,
	input wire out_flag
);
	logic [1:0] pend_q;
	logic       in_acc;
	logic       out_acc;

	assign in_acc  = in_valid & in_ready;
	assign out_acc = out_valid & out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 2'd0;
		end else begin
			pend_q <= pend_q + {1'b0, in_acc} - {1'b0, out_acc};
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_flag_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_flag))
		else $error("result changed while stalled");

	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pend_q != 2'd0)
		else $error("result without a pending candidate");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> pend_q != 2'd2)
		else $error("candidate taken with engine and output both full");

endmodule

bind trial_division_primality_test tdpt_checker u_tdpt_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (candidate.valid),
	.in_ready  (candidate.ready),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.out_flag  (result.prime_flag)
);
`default_nettype wire

// File: verif/primality_checker.sv
// Checker: watches both channels, predicts the prime flag of each candidate and compares results.
`timescale 1ns / 1ps
module primality_checker #(
	parameter int unsigned VALUE_WIDTH = tdpt_pkg::VALUE_WIDTH_DEF
) (
	input  wire   clk,
	input  wire   arst_n,
	tdpt_cand_if  candidate,
	tdpt_flag_if  result,
	output int    mismatches,
	output int    pending
);

	typedef struct {
		logic signed [VALUE_WIDTH-1:0] value;
		logic                          flag;
	} verdict_t;

	verdict_t verdicts[$];

	function automatic logic prime_of(input logic signed [VALUE_WIDTH-1:0] v);
		longint unsigned n;
		longint unsigned d;
		if (v < 0) begin
			return 1'b0;
		end
		n = v;
		if (n < 2) begin
			return 1'b0;
		end
		for (d = 2; d <= n / d; d++) begin
			if (n % d == 0) begin
				return 1'b0;
			end
		end
		return 1'b1;
	endfunction

	initial begin
		mismatches = 0;
		pending = 0;
	end

	always @(posedge clk) begin : watch
		verdict_t head;
		verdict_t fresh;
		if (arst_n) begin
			if (candidate.valid && candidate.ready) begin
				fresh.value = candidate.candidate_value;
				fresh.flag = prime_of(candidate.candidate_value);
				verdicts.push_back(fresh);
			end
			if (result.valid && result.ready) begin
				if (verdicts.size() == 0) begin
					$display("%0t: unexpected transaction, expected none, actual prime_flag %b",
						$time, result.prime_flag);
					mismatches++;
				end else begin
					head = verdicts.pop_front();
					if (result.prime_flag !== head.flag) begin
						$display("%0t: candidate %0d prime_flag expected %b actual %b",
							$time, head.value, head.flag, result.prime_flag);
						mismatches++;
					end
				end
			end
			pending = verdicts.size();
		end
	end

endmodule

// File: verif/tb.sv
// Testbench top: clock, reset, candidate stimulus, result stalls and the final verdict.
`timescale 1ns / 1ps
module tb;

	localparam int unsigned VW = tdpt_pkg::VALUE_WIDTH_DEF;
	localparam int RANDOM_ITEMS = 77;
	localparam int CALM_ITEMS = 20;
	localparam int DRAIN_CYCLES = 64;
	localparam logic signed [VW-1:0] MOST_NEGATIVE = 32'sh8000_0000;
	localparam logic signed [VW-1:0] MOST_POSITIVE = 32'sh7fff_ffff;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	bit   idle_enable = 1'b1;
	int   mismatch_count;
	int   pending_count;

	logic signed [VW-1:0] directed_values[$] = '{
		0, 1, 2, 3, 4, 5, -1, -2, MOST_NEGATIVE, MOST_POSITIVE, 32'sh7fff_fffe,
		32'sh5555_5555, 32'shaaaa_aaaa, 24, 25, 49, 121, 97, 65521, 65535, 65537,
		1022117, 1022119
	};

	tdpt_cand_if #(.VALUE_WIDTH(VW)) candidate_ch ();
	tdpt_flag_if result_ch ();

	trial_division_primality_test #(.VALUE_WIDTH(VW)) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.candidate (candidate_ch.sink),
		.result    (result_ch.source)
	);

	primality_checker #(.VALUE_WIDTH(VW)) i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.candidate  (candidate_ch),
		.result     (result_ch),
		.mismatches (mismatch_count),
		.pending    (pending_count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#100_000_000;
		$display("Some tests failed");
		$finish;
	end

	task automatic send_candidate(input logic signed [VW-1:0] v);
		int gap;
		if (idle_enable && $urandom_range(0, 2) == 0) begin
			gap = $urandom_range(1, 10);
			@(negedge clk);
			candidate_ch.valid <= 1'b0;
			candidate_ch.candidate_value <= $urandom;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		candidate_ch.valid <= 1'b1;
		candidate_ch.candidate_value <= v;
		do @(posedge clk); while (!candidate_ch.ready);
	endtask

	function automatic logic signed [VW-1:0] random_candidate();
		int          roll;
		int unsigned f;
		int unsigned p;
		logic [VW-1:0] bits;
		roll = $urandom_range(0, 9);
		bits = $urandom;
		if (roll < 5) begin
			return $urandom_range(0, 4095);
		end
		case (roll)
			5: return $urandom_range(0, 65535);
			6: return {1'b1, bits[VW-2:0]};
			7: return {1'b0, bits[VW-2:1], 1'b0};
			8: begin
				case ($urandom_range(0, 4))
					0: f = 3;
					1: f = 5;
					2: f = 7;
					3: f = 11;
					default: f = 13;
				endcase
				return VW'($urandom_range(0, 32'h7fff_ffff / f) * f);
			end
			default: begin
				p = $urandom_range(2, 63);
				return VW'(p * p + $urandom_range(0, 2) - 1);
			end
		endcase
	endfunction

	initial begin
		result_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (idle_enable && $urandom_range(0, 7) == 0) begin
				result_ch.ready <= 1'b0;
				repeat ($urandom_range(0, 9)) @(negedge clk);
			end else begin
				result_ch.ready <= 1'b1;
			end
		end
	end

	initial begin
		candidate_ch.valid = 1'b0;
		candidate_ch.candidate_value = '0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;

		foreach (directed_values[i]) begin
			send_candidate(directed_values[i]);
		end
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == RANDOM_ITEMS - CALM_ITEMS) begin
				idle_enable = 1'b0;
			end
			send_candidate(random_candidate());
		end
		@(negedge clk);
		candidate_ch.valid <= 1'b0;

		while (pending_count != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatch_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

// File: files.f
rtl/tdpt_pkg.sv
rtl/tdpt_if.sv
rtl/trial_division_primality_test.sv
rtl/tdpt_checker.sv
verif/primality_checker.sv
verif/tb.sv
